// File: sv/swa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types and constants of the sliding-window ARQ sender.
// ----------------------------------------------------------------------------
package swa_pkg;

  // fixed field widths
  localparam int FRAME_W    = 10;
  localparam int MAX_FRAMES = 1024;
  localparam int KIND_W     = 2;
  localparam int WIN_CFG_W  = 5;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // defaults of the top level parameters
  localparam int MAX_WINDOW_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // configuration reset values
  localparam logic [WIN_CFG_W-1:0] WINDOW_RST  = WIN_CFG_W'(3);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(1000);
  localparam logic [FRAME_W-1:0]   LAST_RST    = FRAME_W'(1023);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW  = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_LAST    = 2'd2
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND    = 2'd0,
    KIND_RETX    = 2'd1,
    KIND_ACK_OK  = 2'd2,
    KIND_ACK_REJ = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_T_RD,
    ST_T_SEND,
    ST_A_RD,
    ST_A_SCAN,
    ST_A_EMIT,
    ST_A_REJ
  } back_state_e;

  typedef struct packed {
    logic [WIN_CFG_W-1:0] window_size;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [FRAME_W-1:0]   last_seq;
  } cfg_t;

  typedef struct packed {
    logic               is_ack;
    logic [FRAME_W-1:0] seq;
  } cmd_t;

endpackage

// File: sv/swa_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_ifs
// Channel interfaces: event input, result output and configuration write.
// ----------------------------------------------------------------------------
interface swa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [swa_pkg::FRAME_W-1:0] ack_seq;

  modport source (output valid, action, ack_seq, input ready);
  modport sink   (input valid, action, ack_seq, output ready);
endinterface

interface swa_out_if;
  logic                        valid;
  logic                        ready;
  logic [swa_pkg::KIND_W-1:0]  kind;
  logic [swa_pkg::FRAME_W-1:0] frame_seq;
  logic [swa_pkg::FRAME_W-1:0] acked_up_to;
  logic                        transfer_done;
  logic                        last_of_run;

  modport source (output valid, kind, frame_seq, acked_up_to, transfer_done, last_of_run,
                  input ready);
  modport sink   (input valid, kind, frame_seq, acked_up_to, transfer_done, last_of_run,
                  output ready);
endinterface

interface swa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swa_pkg::CFG_IDX_W-1:0]  index;
  logic [swa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/sliding_window_arq_sender_core.sv
`timescale 1ns / 1ps
// A tick reads the stamp of the oldest unacked frame, then issues one result per
//   cycle, while the result slot is free, for each send and the retransmit; an ack reads its
//   stamp, then sweeps acked frames one per cycle (up to MAX_WINDOW) before its verdict
// throughput: one event at a time in the back; a two-entry queue takes events meanwhile
// reset: tick clock, pointers and ack flags clear at once; config returns to 3/1000/1023;
//   the send stamp memory is not cleared
// ----------------------------------------------------------------------------
// sliding_window_arq_sender_core
// Sender side of a sliding-window ARQ: issues, retransmits and acknowledges frames.
// ----------------------------------------------------------------------------
module sliding_window_arq_sender_core #(
  parameter int MAX_WINDOW = swa_pkg::MAX_WINDOW_DEF,
  parameter int TIME_BITS  = swa_pkg::TIME_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swa_in_if.sink    item_i,
  swa_out_if.source result_o,
  swa_cfg_if.sink   cfg_i
);

  swa_pkg::cfg_t cfg_q;
  logic          cmd_valid;
  swa_pkg::cmd_t cmd;
  logic          cmd_pop;

  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size   <= swa_pkg::WINDOW_RST;
      cfg_q.timeout_ticks <= swa_pkg::TIMEOUT_RST;
      cfg_q.last_seq      <= swa_pkg::LAST_RST;
    end else if (cfg_i.valid) begin
      case (swa_pkg::cfg_reg_e'(cfg_i.index))
        swa_pkg::REG_WINDOW:  cfg_q.window_size   <= cfg_i.data[swa_pkg::WIN_CFG_W-1:0];
        swa_pkg::REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_i.data[swa_pkg::TIMEOUT_W-1:0];
        swa_pkg::REG_LAST:    cfg_q.last_seq      <= cfg_i.data[swa_pkg::FRAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // event intake and queue
  swa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // window engine
  swa_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .result_o    (result_o)
  );

endmodule

// File: sv/swa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/swa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_front
// Accepts events, classifies them as tick or ack and queues them for the back.
// ----------------------------------------------------------------------------
module swa_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  swa_in_if.sink        item_i,
  output logic          cmd_valid_o,
  output swa_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  localparam int QDEPTH = 2;

  swa_pkg::cmd_t q_mem_q [QDEPTH];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push;
  logic          pop;
  swa_pkg::cmd_t cmd_in;

  // classify the incoming event
  always_comb begin
    cmd_in.is_ack = item_i.action;
    cmd_in.seq    = item_i.ack_seq;
  end

  assign item_i.ready = (count_q < 2'(QDEPTH));
  assign push         = item_i.valid && item_i.ready;
  assign pop          = cmd_pop_i && (count_q != 2'd0);
  assign cmd_valid_o  = (count_q != 2'd0);
  assign cmd_o        = q_mem_q[rd_ptr_q];

  // queue pointers
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: sv/swa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swa_back
// Executes ticks and acks against the window state and drives the results.
// ----------------------------------------------------------------------------
module swa_back #(
  parameter int MAX_WINDOW = swa_pkg::MAX_WINDOW_DEF,
  parameter int TIME_BITS  = swa_pkg::TIME_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  swa_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  swa_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  swa_out_if.source     result_o
);

  localparam int FW = swa_pkg::FRAME_W;

  swa_pkg::back_state_e state_q, state_d;
  logic [TIME_BITS-1:0]  tick_q, tick_d;
  logic [FW-1:0]         acked_q, acked_d;
  logic [FW-1:0]         sent_q, sent_d;
  logic [MAX_WINDOW-1:0] flags_q, flags_d;
  logic [FW-1:0]         seq_q, seq_d;
  logic                  retx_q, retx_d;

  logic                     out_valid_q;
  swa_pkg::kind_e           out_kind_q;
  logic [FW-1:0]            out_seq_q;
  logic [FW-1:0]            out_acked_q;
  logic                     out_done_q;
  logic                     out_last_q;

  logic [FW-1:0]        win;
  logic [FW-1:0]        outstanding;
  logic [FW-1:0]        sent_inc;
  logic [FW-1:0]        acked_inc;
  logic [FW-1:0]        diff;
  logic                 send_cond;
  logic                 next_cond;
  logic                 slot_free;
  logic                 in_win;
  logic [TIME_BITS-1:0] age;
  logic                 timed_out;

  logic                 emit;
  swa_pkg::kind_e       emit_kind;
  logic [FW-1:0]        emit_seq;
  logic                 emit_last;

  logic                 ram_we;
  logic [FW-1:0]        ram_waddr;
  logic [TIME_BITS-1:0] ram_wdata;
  logic [FW-1:0]        ram_raddr;
  logic [TIME_BITS-1:0] ram_rdata;

  // send stamp store
  swa_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (swa_pkg::MAX_FRAMES)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // effective window
  always_comb begin
    if (cfg_i.window_size == '0) begin
      win = FW'(1);
    end else if (cfg_i.window_size > MAX_WINDOW) begin
      win = FW'(MAX_WINDOW);
    end else begin
      win = FW'(cfg_i.window_size);
    end
  end

  // window arithmetic
  assign outstanding = sent_q - acked_q;
  assign sent_inc    = sent_q + FW'(1);
  assign acked_inc   = acked_q + FW'(1);
  assign diff        = seq_q - acked_inc;
  assign send_cond   = (sent_q < cfg_i.last_seq) && (outstanding < win);
  assign next_cond   = (sent_inc < cfg_i.last_seq) && ((sent_inc - acked_q) < win);
  assign slot_free   = !out_valid_q || result_o.ready;
  assign in_win      = (cmd_i.seq > acked_q) && (cmd_i.seq <= sent_q);
  assign age         = tick_q - ram_rdata;
  assign timed_out   = (age >= TIME_BITS'(cfg_i.timeout_ticks));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swa_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.is_ack) begin
            state_d = in_win ? swa_pkg::ST_A_RD : swa_pkg::ST_A_REJ;
          end else begin
            state_d = swa_pkg::ST_T_RD;
          end
        end
      end
      swa_pkg::ST_T_RD: state_d = swa_pkg::ST_T_SEND;
      swa_pkg::ST_T_SEND: begin
        if (!send_cond) begin
          if (!retx_q || slot_free) begin
            state_d = swa_pkg::ST_IDLE;
          end
        end
      end
      swa_pkg::ST_A_RD: state_d = timed_out ? swa_pkg::ST_A_REJ : swa_pkg::ST_A_SCAN;
      swa_pkg::ST_A_SCAN: begin
        if (!((acked_q < seq_q) && flags_q[0])) begin
          state_d = swa_pkg::ST_A_EMIT;
        end
      end
      swa_pkg::ST_A_EMIT, swa_pkg::ST_A_REJ: begin
        if (slot_free) begin
          state_d = swa_pkg::ST_IDLE;
        end
      end
      default: state_d = swa_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    tick_d    = tick_q;
    acked_d   = acked_q;
    sent_d    = sent_q;
    flags_d   = flags_q;
    seq_d     = seq_q;
    retx_d    = retx_q;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = sent_inc;
    ram_wdata = tick_q;
    ram_raddr = acked_inc;
    emit      = 1'b0;
    emit_kind = swa_pkg::KIND_SEND;
    emit_seq  = sent_inc;
    emit_last = 1'b0;
    case (state_q)
      swa_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          seq_d     = cmd_i.seq;
          if (cmd_i.is_ack) begin
            ram_raddr = cmd_i.seq;
          end else begin
            tick_d = tick_q + TIME_BITS'(1);
          end
        end
      end
      swa_pkg::ST_T_RD: begin
        // decide the retransmission of the oldest frame up front
        retx_d = ((acked_q < sent_q) || send_cond) && !flags_q[0] &&
                 ((acked_q < sent_q) ? timed_out : (cfg_i.timeout_ticks == '0));
      end
      swa_pkg::ST_T_SEND: begin
        if (send_cond) begin
          emit      = 1'b1;
          emit_kind = swa_pkg::KIND_SEND;
          emit_seq  = sent_inc;
          emit_last = !next_cond && !retx_q;
          if (slot_free) begin
            sent_d    = sent_inc;
            ram_we    = 1'b1;
            ram_waddr = sent_inc;
          end
        end else if (retx_q) begin
          emit      = 1'b1;
          emit_kind = swa_pkg::KIND_RETX;
          emit_seq  = acked_inc;
          emit_last = 1'b1;
          if (slot_free) begin
            ram_we    = 1'b1;
            ram_waddr = acked_inc;
          end
        end
      end
      swa_pkg::ST_A_RD: begin
        if (!timed_out) begin
          for (int k = 0; k < MAX_WINDOW; k++) begin
            if (diff == FW'(k)) begin
              flags_d[k] = 1'b1;
            end
          end
        end
      end
      swa_pkg::ST_A_SCAN: begin
        // one contiguous acked frame per cycle
        if ((acked_q < seq_q) && flags_q[0]) begin
          acked_d = acked_inc;
          flags_d = flags_q >> 1;
        end
      end
      swa_pkg::ST_A_EMIT: begin
        emit      = 1'b1;
        emit_kind = swa_pkg::KIND_ACK_OK;
        emit_seq  = seq_q;
        emit_last = 1'b1;
      end
      swa_pkg::ST_A_REJ: begin
        emit      = 1'b1;
        emit_kind = swa_pkg::KIND_ACK_REJ;
        emit_seq  = seq_q;
        emit_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swa_pkg::ST_IDLE;
      tick_q      <= '0;
      acked_q     <= '0;
      sent_q      <= '0;
      flags_q     <= '0;
      retx_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      acked_q <= acked_d;
      sent_q  <= sent_d;
      flags_q <= flags_d;
      retx_q  <= retx_d;
      if (emit && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
    if (emit && slot_free) begin
      out_kind_q  <= emit_kind;
      out_seq_q   <= emit_seq;
      out_acked_q <= acked_q;
      out_done_q  <= (acked_q >= cfg_i.last_seq);
      out_last_q  <= emit_last;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.kind          = out_kind_q;
  assign result_o.frame_seq     = out_seq_q;
  assign result_o.acked_up_to   = out_acked_q;
  assign result_o.transfer_done = out_done_q;
  assign result_o.last_of_run   = out_last_q;

`ifndef SYNTHESIS
  // acked pointer never passes sent pointer
  a_acked_le_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acked_q <= sent_q)
    else $error("acked pointer beyond sent pointer");

  // outstanding frames fit the flag window
  a_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sent_q - acked_q) <= FW'(MAX_WINDOW))
    else $error("outstanding frames exceed window");

  // acked pointer moves only while scanning
  a_acked_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acked_q != $past(acked_q)) |-> ($past(state_q) == swa_pkg::ST_A_SCAN))
    else $error("acked pointer moved outside scan");

  // sent pointer steps by one
  a_sent_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sent_q != $past(sent_q)) |-> (sent_q == $past(sent_q) + FW'(1)))
    else $error("sent pointer jumped");
`endif

endmodule

// File: tb/tb_sliding_window_arq_sender_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_arq_sender_core
// Self-checking bench for the ARQ sender: drives ticks and acks through the
// event channel under random gaps and stalls. A scoreboard predicts every
// send, retransmit and ack verdict and checks results in order.
// ----------------------------------------------------------------------------
module tb_sliding_window_arq_sender_core;

  typedef struct {
    swa_pkg::kind_e              kind;
    logic [swa_pkg::FRAME_W-1:0] seq;
    logic [swa_pkg::FRAME_W-1:0] upto;
    bit                          done;
    bit                          last;
  } arq_result_t;

  // predicts frame traffic of the sender and checks it in order
  class arq_scoreboard;
    logic [swa_pkg::WIN_CFG_W-1:0] win_cfg;
    logic [swa_pkg::TIMEOUT_W-1:0] tmo_cfg;
    logic [swa_pkg::FRAME_W-1:0]   last_cfg;
    logic [31:0]                   tick_cnt;
    int                            acked_ptr;
    int                            sent_ptr;
    bit                            flags[swa_pkg::MAX_FRAMES];
    logic [31:0]                   stamps[swa_pkg::MAX_FRAMES];
    arq_result_t                   expected_q[$];
    int                            errors;

    function new();
      win_cfg   = swa_pkg::WINDOW_RST;
      tmo_cfg   = swa_pkg::TIMEOUT_RST;
      last_cfg  = swa_pkg::LAST_RST;
      tick_cnt  = '0;
      acked_ptr = 0;
      sent_ptr  = 0;
      errors    = 0;
      foreach (flags[i]) flags[i] = 1'b0;
    endfunction

    function void write_reg(swa_pkg::cfg_reg_e idx, logic [swa_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        swa_pkg::REG_WINDOW:  win_cfg  = d[swa_pkg::WIN_CFG_W-1:0];
        swa_pkg::REG_TIMEOUT: tmo_cfg  = d[swa_pkg::TIMEOUT_W-1:0];
        swa_pkg::REG_LAST:    last_cfg = d[swa_pkg::FRAME_W-1:0];
        default: ;
      endcase
    endfunction

    function bit aged_out(int f);
      logic [31:0] age;
      age = tick_cnt - stamps[f];
      return age >= {16'd0, tmo_cfg};
    endfunction

    function void push(swa_pkg::kind_e k, int f);
      arq_result_t r;
      r.kind = k;
      r.seq  = f[swa_pkg::FRAME_W-1:0];
      r.upto = acked_ptr[swa_pkg::FRAME_W-1:0];
      r.done = acked_ptr >= int'(last_cfg);
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    // work out the results of one accepted event
    function void note_event(bit is_ack, logic [swa_pkg::FRAME_W-1:0] seq);
      int n0;
      int win;
      int a;
      int i;
      n0 = expected_q.size();
      if (!is_ack) begin
        win = (win_cfg == 0) ? 1 :
              (win_cfg > swa_pkg::MAX_WINDOW_DEF) ? swa_pkg::MAX_WINDOW_DEF : int'(win_cfg);
        tick_cnt = tick_cnt + 1;
        while (sent_ptr < int'(last_cfg) && sent_ptr - acked_ptr < win) begin
          sent_ptr++;
          stamps[sent_ptr] = tick_cnt;
          push(swa_pkg::KIND_SEND, sent_ptr);
        end
        if (acked_ptr < sent_ptr) begin
          if (!flags[acked_ptr + 1] && aged_out(acked_ptr + 1)) begin
            stamps[acked_ptr + 1] = tick_cnt;
            push(swa_pkg::KIND_RETX, acked_ptr + 1);
          end
        end
      end else begin
        a = int'(seq);
        if (a > acked_ptr && a <= sent_ptr && !aged_out(a)) begin
          flags[a] = 1'b1;
          for (i = acked_ptr + 1; i <= a; i++) if (!flags[i]) break;
          acked_ptr = i - 1;
          push(swa_pkg::KIND_ACK_OK, a);
        end else begin
          push(swa_pkg::KIND_ACK_REJ, a);
        end
      end
      if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(arq_result_t got);
      arq_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result kind %0d frame %0d", got.kind, got.seq);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.kind != e.kind) begin
        $error("kind: expected %0d got %0d", e.kind, got.kind); errors++;
      end
      if (got.seq != e.seq) begin
        $error("frame_seq: expected %0d got %0d", e.seq, got.seq); errors++;
      end
      if (got.upto != e.upto) begin
        $error("acked_up_to: expected %0d got %0d", e.upto, got.upto); errors++;
      end
      if (got.done != e.done) begin
        $error("transfer_done: expected %0d got %0d", e.done, got.done); errors++;
      end
      if (got.last != e.last) begin
        $error("last_of_run: expected %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  swa_in_if  item_if();
  swa_out_if res_if();
  swa_cfg_if cfg_if();

  sliding_window_arq_sender_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  arq_scoreboard sb = new();
  bit quiet_mode;
  bit hold_req;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // observe transfers on both channels
  always @(posedge clk_i) begin
    arq_result_t got;
    if (item_if.valid && item_if.ready) sb.note_event(item_if.action, item_if.ack_seq);
    if (res_if.valid && res_if.ready) begin
      got.kind = swa_pkg::kind_e'(res_if.kind);
      got.seq  = res_if.frame_seq;
      got.upto = res_if.acked_up_to;
      got.done = res_if.transfer_done;
      got.last = res_if.last_of_run;
      sb.check_result(got);
    end
  end

  // result side stalls, with one long hold-off on request
  initial begin
    int n;
    res_if.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      n = quiet_mode ? 0 : $urandom_range(0, 8);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (n > 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  task automatic send_event(bit is_ack, logic [swa_pkg::FRAME_W-1:0] seq);
    int n;
    n = quiet_mode ? 0 : $urandom_range(0, 8);
    if (n > 0) begin
      item_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    item_if.valid   <= 1'b1;
    item_if.action  <= is_ack;
    item_if.ack_seq <= seq;
    do @(posedge clk_i); while (!(item_if.valid && item_if.ready));
  endtask

  task automatic write_cfg(swa_pkg::cfg_reg_e idx, logic [swa_pkg::CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  // wait for all results, then let a silent tick finish
  task automatic drain();
    item_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_event();
    logic [swa_pkg::FRAME_W-1:0] a;
    if ($urandom_range(0, 9) < 4) send_event(1'b0, swa_pkg::FRAME_W'($urandom));
    else begin
      if (sb.sent_ptr > sb.acked_ptr && $urandom_range(0, 3) != 0)
        a = swa_pkg::FRAME_W'($urandom_range(sb.acked_ptr + 1, sb.sent_ptr));
      else
        a = swa_pkg::FRAME_W'($urandom_range(0, 1023));
      send_event(1'b1, a);
    end
  endtask

  initial begin
    int lim;
    logic [15:0] tmo_vals[6];
    logic [4:0]  win_vals[6];
    tmo_vals = '{0, 1, 3, 8, 40, 65535};
    win_vals = '{0, 1, 16, 31, 5, 2};
    rst_ni        = 1'b0;
    quiet_mode    = 1'b0;
    hold_req      = 1'b0;
    item_if.valid   <= 1'b0;
    item_if.action  <= 1'b0;
    item_if.ack_seq <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= swa_pkg::REG_WINDOW;
    cfg_if.data     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: out-of-window acks, sends, duplicate and out-of-order acks
    send_event(1'b1, 10'd0);
    send_event(1'b1, 10'd1023);
    send_event(1'b0, 10'd0);
    send_event(1'b1, 10'd2);
    send_event(1'b1, 10'd2);
    send_event(1'b0, 10'd0);
    send_event(1'b1, 10'd1);
    send_event(1'b1, 10'd3);
    send_event(1'b0, 10'd0);
    drain();

    // directed: oversize window with zero timeout
    write_cfg(swa_pkg::REG_WINDOW, 16'd31);
    write_cfg(swa_pkg::REG_TIMEOUT, 16'd0);
    send_event(1'b0, 10'd0);
    send_event(1'b1, 10'(sb.acked_ptr + 1));
    send_event(1'b0, 10'd0);
    drain();

    // directed: zero window with short timeout, late ack
    write_cfg(swa_pkg::REG_WINDOW, 16'd0);
    write_cfg(swa_pkg::REG_TIMEOUT, 16'd2);
    send_event(1'b0, 10'd0);
    send_event(1'b0, 10'd0);
    send_event(1'b0, 10'd0);
    send_event(1'b1, 10'(sb.acked_ptr + 1));
    send_event(1'b0, 10'd0);
    send_event(1'b1, 10'(sb.acked_ptr + 1));
    drain();

    // random phases over varied settings
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(swa_pkg::REG_WINDOW, 16'(win_vals[ph % 6]));
      write_cfg(swa_pkg::REG_TIMEOUT,
                (ph == 2) ? 16'd65535 : tmo_vals[$urandom_range(1, 4)]);
      if (ph == 5) write_cfg(swa_pkg::REG_LAST, 16'd1);
      else if (ph == 7) write_cfg(swa_pkg::REG_LAST, 16'd1023);
      else begin
        lim = sb.sent_ptr + $urandom_range(5, 60);
        write_cfg(swa_pkg::REG_LAST, 16'((lim > 1023) ? 1023 : lim));
      end
      quiet_mode = (ph == 3);
      if (ph == 2) begin
        quiet_mode = 1'b1;
        hold_req   = 1'b1;
      end
      for (int k = 0; k < 30; k++) random_event();
      quiet_mode = 1'b0;
      drain();
    end

    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // overall time limit
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sliding_window_arq_sender_core.f
sv/swa_pkg.sv
sv/swa_ifs.sv
sv/swa_ram.sv
sv/swa_front.sv
sv/swa_back.sv
sv/sliding_window_arq_sender_core.sv
tb/tb_sliding_window_arq_sender_core.sv
